// File: rtl/hbc_pkg.sv
`timescale 1ns / 1ps

package hbc_pkg;

  localparam int unsigned BKT_W     = 4;
  localparam int unsigned SLOT_W    = 5;
  localparam int unsigned DEV_W     = 8;
  localparam int unsigned BLK_W     = 32;
  localparam int unsigned CNT_W     = 8;
  localparam int unsigned STAMP_W   = 32;
  localparam logic [CNT_W-1:0] COUNT_MAX = 8'd255;

  // residue unit consumes this many block bits per cycle
  localparam int unsigned MOD_BITS  = 8;
  localparam int unsigned MOD_STEPS = BLK_W / MOD_BITS;

  typedef enum logic [1:0] {
    CMD_GET     = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_PIN     = 2'd2,
    CMD_UNPIN   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFREE = 2'd1,
    ST_UNDER  = 2'd2,
    ST_OVER   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_SCAN,
    S_DRAIN,
    S_FIN,
    S_UPD
  } state_e;

  typedef struct packed {
    cmd_e                command;
    logic [DEV_W-1:0]    device;
    logic [BLK_W-1:0]    block_number;
    logic [SLOT_W-1:0]   buffer_slot;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot_out;
    logic                need_read;
    status_e             status;
  } rsp_t;

  // one tag RAM word per buffer
  typedef struct packed {
    logic [DEV_W-1:0]    dev;
    logic [BLK_W-1:0]    blk;
    logic                cvalid;
    logic [CNT_W-1:0]    cnt;
    logic [BKT_W-1:0]    bkt;
    logic [STAMP_W-1:0]  stamp;
  } entry_t;

endpackage

// File: rtl/hbc_ram.sv
`timescale 1ns / 1ps

module hbc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: rtl/hashed_block_buffer_cache_unit.sv
`timescale 1ns / 1ps

// Tag manager for a hashed block buffer cache. A transaction is taken when
// start is high and busy is low; its result appears on result_o for exactly
// one cycle with result_valid_o high, in the first cycle that busy is low
// again, and must be taken then: it is never held. A get first forms the home
// bucket (block mod NUM_BUCKETS, eight bits per cycle), then the single read
// port of the tag RAM walks every entry for a hit and a victim, then a drain
// state lets the last compare finish and a final state writes back. Release,
// pin and unpin read their entry when taken and write it back from a single
// update state unless the count would overflow or underflow. Release, pin or unpin
// on a slot past the last buffer is answered with status ok without going
// busy. No clearing pass is needed after reset: a per-buffer written bit makes
// fresh entries read as their reset values.
module hashed_block_buffer_cache_unit #(
  parameter int unsigned NUM_BUFFERS = 32,
  parameter int unsigned NUM_BUCKETS = 13
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  hbc_pkg::req_t cmd_i,
  output logic          result_valid_o,
  output hbc_pkg::rsp_t result_o
);

  localparam int unsigned AW    = $clog2(NUM_BUFFERS);
  localparam int unsigned EW    = $bits(hbc_pkg::entry_t);
  localparam int unsigned MCW   = $clog2(hbc_pkg::MOD_STEPS);
  localparam int unsigned BKT_W = hbc_pkg::BKT_W;

  hbc_pkg::state_e state_q, state_d;

  // control
  logic [NUM_BUFFERS-1:0]      written_q, written_d;
  logic [hbc_pkg::STAMP_W-1:0] stamp_ctr_q, stamp_ctr_d;
  logic                        rvalid_q, rvalid_d;
  logic                        cmp_en_q, cmp_en_d;

  // datapath
  hbc_pkg::req_t               req_q, req_d;
  hbc_pkg::rsp_t               rsp_q, rsp_d;
  logic [hbc_pkg::BLK_W-1:0]   mod_sh_q, mod_sh_d;
  logic [MCW-1:0]              mod_cnt_q, mod_cnt_d;
  logic [BKT_W-1:0]            home_q, home_d;
  logic [AW-1:0]               rd_idx_q, rd_idx_d;
  logic [AW-1:0]               cmp_idx_q, cmp_idx_d;
  logic                        cmp_wr_q, cmp_wr_d;
  logic                        hit_found_q, hit_found_d;
  logic [AW-1:0]               hit_idx_q, hit_idx_d;
  logic [hbc_pkg::STAMP_W-1:0] hit_stamp_q, hit_stamp_d;
  logic [hbc_pkg::CNT_W-1:0]   hit_cnt_q, hit_cnt_d;
  logic                        hit_cv_q, hit_cv_d;
  logic                        vic_found_q, vic_found_d;
  logic [AW-1:0]               vic_idx_q, vic_idx_d;
  logic [BKT_W-1:0]            vic_gap_q, vic_gap_d;
  logic [hbc_pkg::STAMP_W-1:0] vic_stamp_q, vic_stamp_d;

  // RAM port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] ram_rdata;

  hbc_pkg::entry_t  ent;
  hbc_pkg::entry_t  wr_ent;
  logic [BKT_W-1:0] rem;
  logic [BKT_W:0]   rem_t;
  logic [BKT_W:0]   bkt_gap_w;
  logic [BKT_W-1:0] bkt_gap;
  logic             is_hit;
  logic             is_free;
  logic             vic_better;
  logic [hbc_pkg::CNT_W-1:0] cnt_dec;

  hbc_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_BUFFERS)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  function automatic hbc_pkg::entry_t reset_entry(logic [AW-1:0] idx);
    hbc_pkg::entry_t e;
    e        = '0;
    e.stamp  = hbc_pkg::STAMP_W'(idx);
    return e;
  endfunction

  assign busy           = (state_q != hbc_pkg::S_IDLE);
  assign result_valid_o = rvalid_q;
  assign result_o       = rsp_q;
  assign ram_wdata      = wr_ent;

  // entry under compare; never-written buffers read as their reset value
  always_comb begin
    ent = cmp_wr_q ? hbc_pkg::entry_t'(ram_rdata) : reset_entry(cmp_idx_q);
  end

  // residue step: eight restoring steps on a narrow remainder
  always_comb begin
    rem   = home_q;
    rem_t = '0;
    for (int k = 0; k < hbc_pkg::MOD_BITS; k++) begin
      rem_t = {rem, mod_sh_q[hbc_pkg::BLK_W-1-k]};
      if (rem_t >= (BKT_W+1)'(NUM_BUCKETS)) begin
        rem_t = rem_t - (BKT_W+1)'(NUM_BUCKETS);
      end
      rem = rem_t[BKT_W-1:0];
    end
  end

  // hit and victim compare for one entry
  always_comb begin
    if (ent.bkt >= home_q) begin
      bkt_gap_w = {1'b0, ent.bkt} - {1'b0, home_q};
    end else begin
      bkt_gap_w = {1'b0, ent.bkt} + (BKT_W+1)'(NUM_BUCKETS) - {1'b0, home_q};
    end
    bkt_gap = bkt_gap_w[BKT_W-1:0];
    is_hit  = (ent.bkt == home_q) && (ent.dev == req_q.device) &&
              (ent.blk == req_q.block_number);
    is_free = (ent.cnt == '0);
    vic_better = !vic_found_q || (bkt_gap < vic_gap_q) ||
                 ((bkt_gap == vic_gap_q) && (ent.stamp < vic_stamp_q));
    cnt_dec = ent.cnt - 1'b1;
  end

  always_comb begin
    state_d     = state_q;
    written_d   = written_q;
    stamp_ctr_d = stamp_ctr_q;
    rvalid_d    = 1'b0;
    cmp_en_d    = 1'b0;
    req_d       = req_q;
    rsp_d       = rsp_q;
    mod_sh_d    = mod_sh_q;
    mod_cnt_d   = mod_cnt_q;
    home_d      = home_q;
    rd_idx_d    = rd_idx_q;
    cmp_idx_d   = cmp_idx_q;
    cmp_wr_d    = cmp_wr_q;
    hit_found_d = hit_found_q;
    hit_idx_d   = hit_idx_q;
    hit_stamp_d = hit_stamp_q;
    hit_cnt_d   = hit_cnt_q;
    hit_cv_d    = hit_cv_q;
    vic_found_d = vic_found_q;
    vic_idx_d   = vic_idx_q;
    vic_gap_d   = vic_gap_q;
    vic_stamp_d = vic_stamp_q;
    ram_we      = 1'b0;
    ram_waddr   = cmp_idx_q;
    ram_raddr   = rd_idx_q;
    wr_ent      = ent;

    // compare stage handles the entry whose read was issued in the cycle before
    if (cmp_en_q) begin
      if (is_hit && (!hit_found_q || (ent.stamp > hit_stamp_q))) begin
        hit_found_d = 1'b1;
        hit_idx_d   = cmp_idx_q;
        hit_stamp_d = ent.stamp;
        hit_cnt_d   = ent.cnt;
        hit_cv_d    = ent.cvalid;
      end
      if (is_free && vic_better) begin
        vic_found_d = 1'b1;
        vic_idx_d   = cmp_idx_q;
        vic_gap_d   = bkt_gap;
        vic_stamp_d = ent.stamp;
      end
    end

    unique case (state_q)
      hbc_pkg::S_IDLE: begin
        if (start) begin
          req_d = cmd_i;
          if (cmd_i.command == hbc_pkg::CMD_GET) begin
            mod_sh_d    = cmd_i.block_number;
            mod_cnt_d   = '0;
            home_d      = '0;
            hit_found_d = 1'b0;
            vic_found_d = 1'b0;
            state_d     = hbc_pkg::S_MOD;
          end else if (32'(cmd_i.buffer_slot) >= NUM_BUFFERS) begin
            rsp_d.slot_out  = cmd_i.buffer_slot;
            rsp_d.need_read = 1'b0;
            rsp_d.status    = hbc_pkg::ST_OK;
            rvalid_d        = 1'b1;
          end else begin
            ram_raddr = AW'(cmd_i.buffer_slot);
            cmp_idx_d = AW'(cmd_i.buffer_slot);
            cmp_wr_d  = written_q[AW'(cmd_i.buffer_slot)];
            state_d   = hbc_pkg::S_UPD;
          end
        end
      end

      hbc_pkg::S_MOD: begin
        home_d    = rem;
        mod_sh_d  = mod_sh_q << hbc_pkg::MOD_BITS;
        mod_cnt_d = mod_cnt_q + 1'b1;
        if (mod_cnt_q == MCW'(hbc_pkg::MOD_STEPS - 1)) begin
          rd_idx_d = '0;
          state_d  = hbc_pkg::S_SCAN;
        end
      end

      hbc_pkg::S_SCAN: begin
        ram_raddr = rd_idx_q;
        cmp_en_d  = 1'b1;
        cmp_idx_d = rd_idx_q;
        cmp_wr_d  = written_q[rd_idx_q];
        rd_idx_d  = rd_idx_q + 1'b1;
        if (rd_idx_q == AW'(NUM_BUFFERS - 1)) begin
          state_d = hbc_pkg::S_DRAIN;
        end
      end

      hbc_pkg::S_DRAIN: begin
        state_d = hbc_pkg::S_FIN;
      end

      hbc_pkg::S_FIN: begin
        rvalid_d        = 1'b1;
        rsp_d.need_read = 1'b0;
        rsp_d.status    = hbc_pkg::ST_OK;
        wr_ent.dev      = req_q.device;
        wr_ent.blk      = req_q.block_number;
        wr_ent.cvalid   = 1'b1;
        wr_ent.bkt      = home_q;
        if (hit_found_q) begin
          rsp_d.slot_out = hbc_pkg::SLOT_W'(hit_idx_q);
          if (hit_cnt_q == hbc_pkg::COUNT_MAX) begin
            rsp_d.status = hbc_pkg::ST_OVER;
          end else begin
            rsp_d.need_read = !hit_cv_q;
            wr_ent.cnt      = hit_cnt_q + 1'b1;
            wr_ent.stamp    = hit_stamp_q;
            ram_we          = 1'b1;
            ram_waddr       = hit_idx_q;
            written_d[hit_idx_q] = 1'b1;
          end
        end else if (vic_found_q) begin
          rsp_d.slot_out  = hbc_pkg::SLOT_W'(vic_idx_q);
          rsp_d.need_read = 1'b1;
          wr_ent.cnt      = hbc_pkg::CNT_W'(1);
          wr_ent.stamp    = stamp_ctr_q;
          stamp_ctr_d     = stamp_ctr_q + 1'b1;
          ram_we          = 1'b1;
          ram_waddr       = vic_idx_q;
          written_d[vic_idx_q] = 1'b1;
        end else begin
          rsp_d.slot_out = '0;
          rsp_d.status   = hbc_pkg::ST_NOFREE;
        end
        state_d = hbc_pkg::S_IDLE;
      end

      hbc_pkg::S_UPD: begin
        rvalid_d        = 1'b1;
        rsp_d.slot_out  = req_q.buffer_slot;
        rsp_d.need_read = 1'b0;
        rsp_d.status    = hbc_pkg::ST_OK;
        if (req_q.command == hbc_pkg::CMD_PIN) begin
          if (ent.cnt == hbc_pkg::COUNT_MAX) begin
            rsp_d.status = hbc_pkg::ST_OVER;
          end else begin
            wr_ent.cnt = ent.cnt + 1'b1;
            ram_we     = 1'b1;
          end
        end else begin
          if (ent.cnt == '0) begin
            rsp_d.status = hbc_pkg::ST_UNDER;
          end else begin
            wr_ent.cnt = cnt_dec;
            ram_we     = 1'b1;
            // bucket already matches the tag's home bucket
            if ((req_q.command == hbc_pkg::CMD_RELEASE) && (cnt_dec == '0)) begin
              wr_ent.stamp = stamp_ctr_q;
              stamp_ctr_d  = stamp_ctr_q + 1'b1;
            end
          end
        end
        if (ram_we) begin
          written_d[cmp_idx_q] = 1'b1;
        end
        state_d = hbc_pkg::S_IDLE;
      end

      default: begin
        state_d = hbc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hbc_pkg::S_IDLE;
      written_q   <= '0;
      stamp_ctr_q <= hbc_pkg::STAMP_W'(NUM_BUFFERS);
      rvalid_q    <= 1'b0;
      cmp_en_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      written_q   <= written_d;
      stamp_ctr_q <= stamp_ctr_d;
      rvalid_q    <= rvalid_d;
      cmp_en_q    <= cmp_en_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    rsp_q       <= rsp_d;
    mod_sh_q    <= mod_sh_d;
    mod_cnt_q   <= mod_cnt_d;
    home_q      <= home_d;
    rd_idx_q    <= rd_idx_d;
    cmp_idx_q   <= cmp_idx_d;
    cmp_wr_q    <= cmp_wr_d;
    hit_found_q <= hit_found_d;
    hit_idx_q   <= hit_idx_d;
    hit_stamp_q <= hit_stamp_d;
    hit_cnt_q   <= hit_cnt_d;
    hit_cv_q    <= hit_cv_d;
    vic_found_q <= vic_found_d;
    vic_idx_q   <= vic_idx_d;
    vic_gap_q   <= vic_gap_d;
    vic_stamp_q <= vic_stamp_d;
  end

endmodule

// File: bench/hbc_cache_checker.sv
`timescale 1ns / 1ps

module hbc_cache_checker
  import hbc_pkg::*;
#(
  parameter int unsigned NUM_BUFFERS = 32,
  parameter int unsigned NUM_BUCKETS = 13
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  req_t        cmd_i,
  input  logic        result_valid_i,
  input  rsp_t        result_i,
  input  logic        drain_done_i,
  output int unsigned fail_count_o
);

  logic [DEV_W-1:0]   tag_dev   [NUM_BUFFERS];
  logic [BLK_W-1:0]   tag_blk   [NUM_BUFFERS];
  logic               cont_ok   [NUM_BUFFERS];
  logic [CNT_W-1:0]   refs      [NUM_BUFFERS];
  logic [BKT_W-1:0]   bucket    [NUM_BUFFERS];
  logic [STAMP_W-1:0] stamp     [NUM_BUFFERS];
  logic [STAMP_W-1:0] next_stamp;

  rsp_t expected_rsp_q[$];
  logic leftover_checked = 1'b0;

  function automatic void clear_cache_model();
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      tag_dev[i] = '0;
      tag_blk[i] = '0;
      cont_ok[i] = 1'b0;
      refs[i]    = '0;
      bucket[i]  = '0;
      stamp[i]   = STAMP_W'(i);
    end
    next_stamp = STAMP_W'(NUM_BUFFERS);
  endfunction

  function automatic rsp_t predict_cache_op(req_t req);
    rsp_t        rsp;
    int          hit;
    int          victim;
    int          idx;
    int unsigned home;
    int unsigned b;
    rsp.slot_out  = '0;
    rsp.need_read = 1'b0;
    rsp.status    = ST_OK;
    if (req.command == CMD_GET) begin
      home = req.block_number % NUM_BUCKETS;
      hit  = -1;
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        if (bucket[i] == home && tag_dev[i] == req.device &&
            tag_blk[i] == req.block_number) begin
          if (hit < 0 || stamp[i] > stamp[hit]) hit = i;
        end
      end
      if (hit >= 0) begin
        rsp.slot_out = SLOT_W'(hit);
        if (refs[hit] >= COUNT_MAX) begin
          rsp.status = ST_OVER;
        end else begin
          refs[hit]     = refs[hit] + 1'b1;
          rsp.need_read = !cont_ok[hit];
          cont_ok[hit]  = 1'b1;
        end
        return rsp;
      end
      // recycle: least recent free buffer, buckets walked from home onward
      victim = -1;
      for (int off = 0; off < NUM_BUCKETS && victim < 0; off++) begin
        b = (home + off) % NUM_BUCKETS;
        for (int i = 0; i < NUM_BUFFERS; i++) begin
          if (bucket[i] == b && refs[i] == 0) begin
            if (victim < 0 || stamp[i] < stamp[victim]) victim = i;
          end
        end
      end
      if (victim < 0) begin
        rsp.status = ST_NOFREE;
        return rsp;
      end
      tag_dev[victim] = req.device;
      tag_blk[victim] = req.block_number;
      refs[victim]    = CNT_W'(1);
      bucket[victim]  = BKT_W'(home);
      stamp[victim]   = next_stamp;
      next_stamp      = next_stamp + 1'b1;
      cont_ok[victim] = 1'b1;
      rsp.slot_out    = SLOT_W'(victim);
      rsp.need_read   = 1'b1;
      return rsp;
    end
    rsp.slot_out = req.buffer_slot;
    idx = int'(req.buffer_slot);
    if (idx >= NUM_BUFFERS) return rsp;
    if (req.command == CMD_PIN) begin
      if (refs[idx] >= COUNT_MAX) rsp.status = ST_OVER;
      else refs[idx] = refs[idx] + 1'b1;
      return rsp;
    end
    if (refs[idx] == 0) begin
      rsp.status = ST_UNDER;
      return rsp;
    end
    refs[idx] = refs[idx] - 1'b1;
    if (req.command == CMD_RELEASE && refs[idx] == 0) begin
      bucket[idx] = BKT_W'(tag_blk[idx] % NUM_BUCKETS);
      stamp[idx]  = next_stamp;
      next_stamp  = next_stamp + 1'b1;
    end
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      clear_cache_model();
      expected_rsp_q.delete();
    end else begin
      // results first: a result never belongs to a transaction of this edge
      if (result_valid_i) begin
        if (expected_rsp_q.size() == 0) begin
          $display("%0t: unexpected result slot=%0d need_read=%0d status=%0d",
                   $time, result_i.slot_out, result_i.need_read, result_i.status);
          fail_count_o++;
        end else begin
          want = expected_rsp_q.pop_front();
          if (result_i.slot_out !== want.slot_out ||
              result_i.need_read !== want.need_read ||
              result_i.status !== want.status) begin
            $display("%0t: mismatch exp slot=%0d need_read=%0d status=%0d",
                     $time, want.slot_out, want.need_read, want.status);
            $display("%0t:          got slot=%0d need_read=%0d status=%0d",
                     $time, result_i.slot_out, result_i.need_read, result_i.status);
            fail_count_o++;
          end
        end
      end
      if (start_i && !busy_i) expected_rsp_q.push_back(predict_cache_op(cmd_i));
      if (drain_done_i && !leftover_checked) begin
        leftover_checked = 1'b1;
        if (expected_rsp_q.size() != 0) begin
          $display("%0t: %0d expected results never arrived", $time,
                   expected_rsp_q.size());
          fail_count_o++;
        end
      end
    end
  end

endmodule

// File: bench/hashed_block_buffer_cache_unit_tb.sv
`timescale 1ns / 1ps

module hashed_block_buffer_cache_unit_tb;
  import hbc_pkg::*;

  localparam int unsigned NUM_BUFFERS = 32;
  localparam int unsigned NUM_BUCKETS = 13;
  localparam int unsigned TAG_POOL    = 40;
  localparam int unsigned ITEM_GOAL   = 1550;
  localparam int unsigned STALL_LIMIT = 4000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  req_t        cmd_i = '0;
  logic        result_valid_o;
  rsp_t        result_o;
  logic        drain_done = 1'b0;
  int unsigned fail_count;

  cmd_e             pending_cmds[$];
  logic [SLOT_W-1:0] held_slots[$];
  logic [DEV_W-1:0] pool_dev[TAG_POOL];
  logic [BLK_W-1:0] pool_blk[TAG_POOL];
  int unsigned      burst_left = 0;
  int unsigned      items_sent = 0;
  int unsigned      stall_cycles = 0;

  always #5 clk_i = ~clk_i;

  hashed_block_buffer_cache_unit #(
    .NUM_BUFFERS(NUM_BUFFERS),
    .NUM_BUCKETS(NUM_BUCKETS)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  hbc_cache_checker #(
    .NUM_BUFFERS(NUM_BUFFERS),
    .NUM_BUCKETS(NUM_BUCKETS)
  ) i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .cmd_i         (cmd_i),
    .result_valid_i(result_valid_o),
    .result_i      (result_o),
    .drain_done_i  (drain_done),
    .fail_count_o  (fail_count)
  );

  // track outstanding transactions; granted buffers feed later releases
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o && pending_cmds.size() != 0) begin
        if (pending_cmds.pop_front() == CMD_GET && result_o.status == ST_OK)
          held_slots.push_back(result_o.slot_out);
      end
      if (start && !busy) pending_cmds.push_back(cmd_i.command);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || result_valid_o) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, stall_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic req_t random_req();
    req_t req;
    req.command      = cmd_e'($urandom_range(0, 3));
    req.device       = DEV_W'($urandom);
    req.block_number = $urandom;
    req.buffer_slot  = SLOT_W'($urandom);
    return req;
  endfunction

  task automatic idle_cycles(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start <= 1'b0;
      cmd_i <= random_req();
    end
  endtask

  task automatic send_req(input cmd_e op, input logic [DEV_W-1:0] dev,
                          input logic [BLK_W-1:0] blk, input logic [SLOT_W-1:0] slot);
    req_t        req;
    int unsigned sel;
    if (burst_left == 0) begin
      sel = $urandom_range(0, 9);
      if (sel < 5) idle_cycles($urandom_range(0, 3));
      else if (sel < 8) idle_cycles($urandom_range(0, 45));
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    req.command      = op;
    req.device       = dev;
    req.block_number = blk;
    req.buffer_slot  = slot;
    @(negedge clk_i);
    start <= 1'b1;
    cmd_i <= req;
    do @(posedge clk_i); while (busy);
    items_sent++;
  endtask

  task automatic slot_op(input cmd_e op, input logic [SLOT_W-1:0] slot);
    send_req(op, DEV_W'($urandom), $urandom, slot);
  endtask

  task automatic get_block(input logic [DEV_W-1:0] dev, input logic [BLK_W-1:0] blk);
    send_req(CMD_GET, dev, blk, SLOT_W'($urandom));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_cmds.size() != 0) @(negedge clk_i);
  endtask

  task automatic release_all_held();
    wait_drained();
    while (held_slots.size() != 0) slot_op(CMD_RELEASE, held_slots.pop_front());
    wait_drained();
  endtask

  task automatic refresh_pool_entry(input int unsigned i);
    pool_dev[i] = DEV_W'($urandom);
    // some entries share a block with another device to test device compare
    if ($urandom_range(0, 9) < 3) pool_blk[i] = pool_blk[$urandom_range(0, TAG_POOL - 1)];
    else pool_blk[i] = $urandom;
  endtask

  task automatic random_ops(input int unsigned n);
    int unsigned sel;
    int unsigned pi;
    int unsigned hi;
    req_t        req;
    repeat (n) begin
      sel = $urandom_range(0, 99);
      if (held_slots.size() > 24 && sel < 60) sel = 50;
      if (sel < 45) begin
        pi = $urandom_range(0, TAG_POOL - 1);
        if ($urandom_range(0, 9) == 0) refresh_pool_entry(pi);
        get_block(pool_dev[pi], pool_blk[pi]);
      end else if (sel < 75) begin
        if (held_slots.size() != 0) begin
          hi = $urandom_range(0, held_slots.size() - 1);
          req.buffer_slot = held_slots[hi];
          held_slots.delete(hi);
          slot_op(CMD_RELEASE, req.buffer_slot);
        end else begin
          slot_op(CMD_RELEASE, SLOT_W'($urandom));
        end
      end else if (sel < 87) begin
        if (held_slots.size() != 0 && $urandom_range(0, 1))
          req.buffer_slot = held_slots[$urandom_range(0, held_slots.size() - 1)];
        else
          req.buffer_slot = SLOT_W'($urandom);
        slot_op($urandom_range(0, 1) ? CMD_PIN : CMD_UNPIN, req.buffer_slot);
      end else begin
        req = random_req();
        send_req(req.command, req.device, req.block_number, req.buffer_slot);
      end
    end
  endtask

  // claim more buffers than exist so the no-free-buffer path is taken
  task automatic fill_cache();
    release_all_held();
    repeat (NUM_BUFFERS + 3) get_block(DEV_W'($urandom), $urandom);
    release_all_held();
  endtask

  // drive one buffer to full count, then back down to free
  task automatic saturate_count();
    logic [DEV_W-1:0]  dev;
    logic [BLK_W-1:0]  blk;
    logic [SLOT_W-1:0] slot;
    release_all_held();
    dev = DEV_W'($urandom);
    blk = $urandom;
    get_block(dev, blk);
    wait_drained();
    if (held_slots.size() != 0) begin
      slot = held_slots.pop_back();
      repeat (254) slot_op(CMD_PIN, slot);
      slot_op(CMD_PIN, slot);
      get_block(dev, blk);
      repeat (254) slot_op(CMD_UNPIN, slot);
      slot_op(CMD_RELEASE, slot);
    end
  endtask

  initial begin
    for (int i = 0; i < TAG_POOL; i++) begin
      pool_dev[i] = DEV_W'($urandom);
      pool_blk[i] = $urandom;
    end
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // every buffer matches device 0 block 0 after reset: the newest one wins
    get_block('0, '0);
    get_block('0, '0);
    slot_op(CMD_RELEASE, SLOT_W'(NUM_BUFFERS - 1));
    slot_op(CMD_RELEASE, SLOT_W'(NUM_BUFFERS - 1));
    slot_op(CMD_RELEASE, SLOT_W'(NUM_BUFFERS - 1));
    slot_op(CMD_UNPIN, SLOT_W'(NUM_BUFFERS - 1));
    get_block('1, '1);
    get_block('0, '1);
    get_block('1, '0);
    get_block('1, '1);
    get_block(8'h5a, 32'd13);
    get_block(8'ha5, 32'd12);
    slot_op(CMD_PIN, '0);
    slot_op(CMD_UNPIN, '0);
    slot_op(CMD_UNPIN, '0);
    slot_op(CMD_PIN, '1);
    slot_op(CMD_UNPIN, '1);
    slot_op(CMD_RELEASE, '1);
    release_all_held();

    random_ops(350);
    fill_cache();
    random_ops(250);
    saturate_count();
    random_ops(150);
    fill_cache();
    while (items_sent < ITEM_GOAL) random_ops(1);

    wait_drained();
    repeat (NUM_BUFFERS + 10) @(posedge clk_i);
    @(negedge clk_i);
    drain_done <= 1'b1;
    repeat (2) @(posedge clk_i);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
